[rtl/sbcg_pkg.sv]
// Shared constants, types and controller/datapath interface for the scaled blit generator.
package sbcg_pkg;

  localparam int SCREEN_WIDTH  = 396;
  localparam int SCREEN_HEIGHT = 224;
  localparam int FRAC_BITS     = 16;

  localparam int TEX_W   = 12;
  localparam int TEX_MAX = (1 << TEX_W) - 1;
  localparam int POS_W   = 16;
  localparam int SIZE_W  = 13;
  localparam int SCR_W   = 13;
  localparam int SX_W    = $clog2(SCREEN_WIDTH + 1);
  localparam int SY_W    = $clog2(SCREEN_HEIGHT + 1);
  localparam int FIX_W   = TEX_W + FRAC_BITS + 1;
  localparam int NUM_W   = TEX_W + FRAC_BITS;
  localparam int DEN_W   = TEX_W;
  localparam int DIV_CNT_W = $clog2(NUM_W);

  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_TEX_WIDTH  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_TEX_HEIGHT = 1'b1;

  localparam logic OP_START = 1'b0;
  localparam logic OP_NEXT  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLIP,
    S_EMPTY,
    S_DIV_X,
    S_WAIT_X,
    S_MUL_X,
    S_ORG_X,
    S_DIV_Y,
    S_WAIT_Y,
    S_MUL_Y,
    S_ORG_Y
  } state_t;

  typedef struct packed {
    logic capture;
    logic clip_load;
    logic emit_empty;
    logic axis_y;
    logic div_start;
    logic step_load;
    logic mul_load;
    logic origin_load;
    logic activate;
    logic pixel_step;
  } cmd_t;

  typedef struct packed {
    logic clip_ok;
    logic div_done;
    logic res_free;
  } status_t;

  typedef struct packed {
    logic             ok;
    logic [SCR_W-1:0] s0;
    logic [SCR_W-1:0] cnt;
    logic [TEX_W-1:0] us;
    logic [TEX_W-1:0] diff_mag;
    logic             diff_neg;
    logic [DEN_W-1:0] den;
    logic [TEX_W-1:0] off;
  } axis_setup_t;

endpackage

[rtl/sbcg_regs.sv]
// APB-style configuration registers: texture width and height.
module sbcg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sbcg_pkg::ADDR_W-1:0]    paddr,
  input  logic [sbcg_pkg::DATA_W-1:0]    pwdata,
  output logic [sbcg_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  output logic [sbcg_pkg::TEX_W-1:0]     tex_width,
  output logic [sbcg_pkg::TEX_W-1:0]     tex_height
);

  logic [sbcg_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           wr_en;

  assign reg_idx = paddr[sbcg_pkg::ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width  <= sbcg_pkg::TEX_W'(1);
      tex_height <= sbcg_pkg::TEX_W'(1);
    end else if (wr_en) begin
      unique case (reg_idx)
        sbcg_pkg::REG_TEX_WIDTH:  tex_width  <= pwdata[sbcg_pkg::TEX_W-1:0];
        sbcg_pkg::REG_TEX_HEIGHT: tex_height <= pwdata[sbcg_pkg::TEX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sbcg_pkg::REG_TEX_WIDTH:  prdata = sbcg_pkg::DATA_W'(tex_width);
      sbcg_pkg::REG_TEX_HEIGHT: prdata = sbcg_pkg::DATA_W'(tex_height);
      default:                  prdata = '0;
    endcase
  end

endmodule

[rtl/sbcg_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module sbcg_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [sbcg_pkg::NUM_W-1:0]   num,
  input  logic [sbcg_pkg::DEN_W-1:0]   den,
  output logic                         done,
  output logic [sbcg_pkg::NUM_W-1:0]   quot
);

  logic                             busy;
  logic [sbcg_pkg::DIV_CNT_W-1:0]   cnt;
  logic [sbcg_pkg::DEN_W-1:0]       rem;
  logic [sbcg_pkg::DEN_W-1:0]       divisor;
  logic [sbcg_pkg::DEN_W:0]         trial;
  logic [sbcg_pkg::DEN_W:0]         diff;

  assign trial = {rem, quot[sbcg_pkg::NUM_W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == sbcg_pkg::DIV_CNT_W'(sbcg_pkg::NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot    <= num;
      rem     <= '0;
      divisor <= den;
    end else if (busy) begin
      if (!diff[sbcg_pkg::DEN_W]) begin
        rem  <= diff[sbcg_pkg::DEN_W-1:0];
        quot <= {quot[sbcg_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem  <= trial[sbcg_pkg::DEN_W-1:0];
        quot <= {quot[sbcg_pkg::NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

[rtl/sbcg_dp.sv]
// Datapath: clipping, step and origin setup, pixel counters and result register.
module sbcg_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  sbcg_pkg::cmd_t                     cmd,
  output sbcg_pkg::status_t                  status,
  input  logic [sbcg_pkg::TEX_W-1:0]         tex_width,
  input  logic [sbcg_pkg::TEX_W-1:0]         tex_height,
  input  logic signed [sbcg_pkg::POS_W-1:0]  dest_x,
  input  logic signed [sbcg_pkg::POS_W-1:0]  dest_y,
  input  logic signed [sbcg_pkg::SIZE_W-1:0] dest_w,
  input  logic signed [sbcg_pkg::SIZE_W-1:0] dest_h,
  input  logic signed [sbcg_pkg::POS_W-1:0]  src_x,
  input  logic signed [sbcg_pkg::POS_W-1:0]  src_y,
  input  logic [sbcg_pkg::TEX_W-1:0]         src_w,
  input  logic [sbcg_pkg::TEX_W-1:0]         src_h,
  input  logic                               res_stall,
  output logic                               res_valid,
  output logic                               empty_res,
  output logic [sbcg_pkg::SX_W-1:0]          screen_x,
  output logic [sbcg_pkg::SY_W-1:0]          screen_y,
  output logic [sbcg_pkg::TEX_W-1:0]         tex_x,
  output logic [sbcg_pkg::TEX_W-1:0]         tex_y,
  output logic                               last
);

  localparam int EXT_W  = sbcg_pkg::POS_W + 3;
  localparam int PROD_W = sbcg_pkg::FIX_W + sbcg_pkg::TEX_W + 1;
  localparam int INT_W  = sbcg_pkg::FIX_W + 1 - sbcg_pkg::FRAC_BITS;

  function automatic sbcg_pkg::axis_setup_t clip_axis(
    logic signed [sbcg_pkg::POS_W-1:0]  pos,
    logic signed [sbcg_pkg::SIZE_W-1:0] size,
    logic signed [sbcg_pkg::POS_W-1:0]  spos,
    logic [sbcg_pkg::TEX_W-1:0]         ssize,
    logic [sbcg_pkg::TEX_W-1:0]         tsize,
    logic [sbcg_pkg::SCR_W-1:0]         scr
  );
    sbcg_pkg::axis_setup_t             r;
    logic [sbcg_pkg::TEX_W-1:0]        tlast;
    logic signed [EXT_W-1:0]           tlast_s;
    logic signed [EXT_W-1:0]           sp;
    logic signed [EXT_W-1:0]           se;
    logic [sbcg_pkg::TEX_W-1:0]        us;
    logic [sbcg_pkg::TEX_W-1:0]        ue;
    logic [sbcg_pkg::TEX_W-1:0]        tmp;
    logic [sbcg_pkg::SIZE_W-1:0]       mag;
    logic signed [EXT_W-1:0]           s0;
    logic signed [EXT_W-1:0]           e;
    logic signed [EXT_W-1:0]           lastpix;
    logic signed [EXT_W-1:0]           cnt;
    logic signed [EXT_W-1:0]           off;
    logic signed [sbcg_pkg::TEX_W:0]   diff;
    tlast   = (tsize == '0) ? '0 : tsize - 1'b1;
    tlast_s = $signed(EXT_W'(tlast));
    sp      = EXT_W'(spos);
    se      = EXT_W'(spos) + $signed(EXT_W'(ssize)) - $signed(EXT_W'(1));
    if (sp < 0) us = '0;
    else if (sp > tlast_s) us = tlast;
    else us = sp[sbcg_pkg::TEX_W-1:0];
    if (se < 0) ue = '0;
    else if (se > tlast_s) ue = tlast;
    else ue = se[sbcg_pkg::TEX_W-1:0];
    mag = size[sbcg_pkg::SIZE_W-1] ? sbcg_pkg::SIZE_W'(-size) : size;
    if (size[sbcg_pkg::SIZE_W-1]) begin
      tmp = us;
      us  = ue;
      ue  = tmp;
    end
    s0      = (pos < 0) ? '0 : EXT_W'(pos);
    e       = EXT_W'(pos) + $signed(EXT_W'(mag)) - $signed(EXT_W'(1));
    lastpix = $signed(EXT_W'(scr)) - $signed(EXT_W'(1));
    if (e > lastpix) e = lastpix;
    cnt  = e - s0 + $signed(EXT_W'(1));
    off  = s0 - EXT_W'(pos);
    diff = $signed({1'b0, ue}) - $signed({1'b0, us});
    r.ok       = (cnt > 0) && (size != '0) && (ssize != '0);
    r.s0       = s0[sbcg_pkg::SCR_W-1:0];
    r.cnt      = cnt[sbcg_pkg::SCR_W-1:0];
    r.us       = us;
    r.diff_neg = diff[sbcg_pkg::TEX_W];
    r.diff_mag = diff[sbcg_pkg::TEX_W] ? sbcg_pkg::TEX_W'(-diff)
                                       : diff[sbcg_pkg::TEX_W-1:0];
    r.den      = sbcg_pkg::DEN_W'(mag - 1'b1);
    r.off      = off[sbcg_pkg::TEX_W-1:0];
    return r;
  endfunction

  function automatic logic [sbcg_pkg::TEX_W-1:0] tex_coord(
    logic signed [sbcg_pkg::FIX_W:0] v
  );
    logic [INT_W-1:0] ip;
    ip = v[sbcg_pkg::FIX_W:sbcg_pkg::FRAC_BITS];
    if (v < 0) return '0;
    if (ip > INT_W'(sbcg_pkg::TEX_MAX)) return sbcg_pkg::TEX_W'(sbcg_pkg::TEX_MAX);
    return ip[sbcg_pkg::TEX_W-1:0];
  endfunction

  // latched start transaction
  logic signed [sbcg_pkg::POS_W-1:0]  blit_dest_x, blit_dest_y;
  logic signed [sbcg_pkg::SIZE_W-1:0] blit_dest_w, blit_dest_h;
  logic signed [sbcg_pkg::POS_W-1:0]  blit_src_x, blit_src_y;
  logic [sbcg_pkg::TEX_W-1:0]         blit_src_w, blit_src_h;

  sbcg_pkg::axis_setup_t clip_x, clip_y;
  sbcg_pkg::axis_setup_t setup_x, setup_y;
  sbcg_pkg::axis_setup_t setup_sel;

  logic signed [sbcg_pkg::FIX_W-1:0] step_x, step_y, step_sel;
  logic signed [sbcg_pkg::FIX_W:0]   prod;
  logic signed [PROD_W-1:0]          prod_full;
  logic signed [sbcg_pkg::FIX_W-1:0] origin_tex_x, origin_tex_y;
  logic signed [sbcg_pkg::FIX_W:0]   origin_sum;
  logic signed [sbcg_pkg::FIX_W-1:0] step_new;
  logic signed [sbcg_pkg::FIX_W-1:0] acc_x, acc_y;
  logic [sbcg_pkg::SX_W-1:0]         origin_screen_x, cols_total, col_count;
  logic [sbcg_pkg::SY_W-1:0]         origin_screen_y, rows_total, row_count;
  logic                              active;
  logic                              pixel_fire;
  logic                              col_end, row_end;
  logic signed [sbcg_pkg::FIX_W:0]   tex_sum_x, tex_sum_y;

  logic                              div_done;
  logic [sbcg_pkg::NUM_W-1:0]        div_quot;
  logic [sbcg_pkg::NUM_W-1:0]        div_num;

  always_comb begin
    clip_x = clip_axis(blit_dest_x, blit_dest_w, blit_src_x, blit_src_w, tex_width,
                       sbcg_pkg::SCR_W'(sbcg_pkg::SCREEN_WIDTH));
    clip_y = clip_axis(blit_dest_y, blit_dest_h, blit_src_y, blit_src_h, tex_height,
                       sbcg_pkg::SCR_W'(sbcg_pkg::SCREEN_HEIGHT));
  end

  assign setup_sel = cmd.axis_y ? setup_y : setup_x;
  assign step_sel  = cmd.axis_y ? step_y : step_x;
  assign div_num   = {setup_sel.diff_mag, sbcg_pkg::FRAC_BITS'(0)};

  sbcg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (setup_sel.den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    if (setup_sel.den == '0) step_new = '0;
    else if (setup_sel.diff_neg) step_new = -$signed({1'b0, div_quot});
    else step_new = $signed({1'b0, div_quot});
  end

  assign prod_full  = step_sel * $signed({1'b0, setup_sel.off});
  assign origin_sum = $signed({1'b0, setup_sel.us, sbcg_pkg::FRAC_BITS'(0)})
                    + prod;

  assign status.clip_ok  = clip_x.ok & clip_y.ok;
  assign status.div_done = div_done;
  assign status.res_free = !res_valid || !res_stall;

  assign pixel_fire = cmd.pixel_step & active;
  assign col_end    = (col_count == cols_total - 1'b1);
  assign row_end    = (row_count == rows_total - 1'b1);
  assign tex_sum_x  = (sbcg_pkg::FIX_W + 1)'(origin_tex_x) + (sbcg_pkg::FIX_W + 1)'(acc_x);
  assign tex_sum_y  = (sbcg_pkg::FIX_W + 1)'(origin_tex_y) + (sbcg_pkg::FIX_W + 1)'(acc_y);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      blit_dest_x <= dest_x;
      blit_dest_y <= dest_y;
      blit_dest_w <= dest_w;
      blit_dest_h <= dest_h;
      blit_src_x  <= src_x;
      blit_src_y  <= src_y;
      blit_src_w  <= src_w;
      blit_src_h  <= src_h;
    end
    if (cmd.clip_load) begin
      setup_x <= clip_x;
      setup_y <= clip_y;
    end
    if (cmd.mul_load) prod <= prod_full[sbcg_pkg::FIX_W:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active          <= 1'b0;
      step_x          <= '0;
      step_y          <= '0;
      origin_tex_x    <= '0;
      origin_tex_y    <= '0;
      origin_screen_x <= '0;
      origin_screen_y <= '0;
      cols_total      <= '0;
      rows_total      <= '0;
      col_count       <= '0;
      row_count       <= '0;
      acc_x           <= '0;
      acc_y           <= '0;
    end else begin
      if (cmd.capture) active <= 1'b0;
      if (cmd.step_load) begin
        if (cmd.axis_y) step_y <= step_new;
        else step_x <= step_new;
      end
      if (cmd.origin_load) begin
        if (cmd.axis_y) origin_tex_y <= origin_sum[sbcg_pkg::FIX_W-1:0];
        else origin_tex_x <= origin_sum[sbcg_pkg::FIX_W-1:0];
      end
      if (cmd.activate) begin
        active          <= 1'b1;
        origin_screen_x <= setup_x.s0[sbcg_pkg::SX_W-1:0];
        origin_screen_y <= setup_y.s0[sbcg_pkg::SY_W-1:0];
        cols_total      <= setup_x.cnt[sbcg_pkg::SX_W-1:0];
        rows_total      <= setup_y.cnt[sbcg_pkg::SY_W-1:0];
        col_count       <= '0;
        row_count       <= '0;
        acc_x           <= '0;
        acc_y           <= '0;
      end else if (pixel_fire) begin
        if (col_end) begin
          col_count <= '0;
          acc_x     <= '0;
          if (row_end) begin
            row_count <= '0;
            acc_y     <= '0;
            active    <= 1'b0;
          end else begin
            row_count <= row_count + 1'b1;
            acc_y     <= acc_y + step_y;
          end
        end else begin
          col_count <= col_count + 1'b1;
          acc_x     <= acc_x + step_x;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pixel_fire || cmd.emit_empty) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_fire) begin
      empty_res <= 1'b0;
      screen_x  <= origin_screen_x + col_count;
      screen_y  <= origin_screen_y + row_count;
      tex_x     <= tex_coord(tex_sum_x);
      tex_y     <= tex_coord(tex_sum_y);
      last      <= col_end & row_end;
    end else if (cmd.emit_empty) begin
      empty_res <= 1'b1;
      screen_x  <= '0;
      screen_y  <= '0;
      tex_x     <= '0;
      tex_y     <= '0;
      last      <= 1'b0;
    end
  end

endmodule

[rtl/sbcg_ctrl.sv]
// Controller: input handshake and start-setup sequencing.
module sbcg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic                op,
  input  sbcg_pkg::status_t   status,
  output sbcg_pkg::cmd_t      cmd
);

  sbcg_pkg::state_t state, state_next;
  logic             accept;

  assign item_stall = !((state == sbcg_pkg::S_IDLE) && status.res_free);
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) state <= sbcg_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sbcg_pkg::S_IDLE:
        if (accept && op == sbcg_pkg::OP_START) state_next = sbcg_pkg::S_CLIP;
      sbcg_pkg::S_CLIP:
        state_next = status.clip_ok ? sbcg_pkg::S_DIV_X : sbcg_pkg::S_EMPTY;
      sbcg_pkg::S_EMPTY:  state_next = sbcg_pkg::S_IDLE;
      sbcg_pkg::S_DIV_X:  state_next = sbcg_pkg::S_WAIT_X;
      sbcg_pkg::S_WAIT_X: if (status.div_done) state_next = sbcg_pkg::S_MUL_X;
      sbcg_pkg::S_MUL_X:  state_next = sbcg_pkg::S_ORG_X;
      sbcg_pkg::S_ORG_X:  state_next = sbcg_pkg::S_DIV_Y;
      sbcg_pkg::S_DIV_Y:  state_next = sbcg_pkg::S_WAIT_Y;
      sbcg_pkg::S_WAIT_Y: if (status.div_done) state_next = sbcg_pkg::S_MUL_Y;
      sbcg_pkg::S_MUL_Y:  state_next = sbcg_pkg::S_ORG_Y;
      sbcg_pkg::S_ORG_Y:  state_next = sbcg_pkg::S_IDLE;
      default:            state_next = sbcg_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      sbcg_pkg::S_IDLE: begin
        cmd.capture    = accept && op == sbcg_pkg::OP_START;
        cmd.pixel_step = accept && op == sbcg_pkg::OP_NEXT;
      end
      sbcg_pkg::S_CLIP:   cmd.clip_load = 1'b1;
      sbcg_pkg::S_EMPTY:  cmd.emit_empty = 1'b1;
      sbcg_pkg::S_DIV_X:  cmd.div_start = 1'b1;
      sbcg_pkg::S_WAIT_X: cmd.step_load = status.div_done;
      sbcg_pkg::S_MUL_X:  cmd.mul_load = 1'b1;
      sbcg_pkg::S_ORG_X:  cmd.origin_load = 1'b1;
      sbcg_pkg::S_DIV_Y: begin
        cmd.axis_y    = 1'b1;
        cmd.div_start = 1'b1;
      end
      sbcg_pkg::S_WAIT_Y: begin
        cmd.axis_y    = 1'b1;
        cmd.step_load = status.div_done;
      end
      sbcg_pkg::S_MUL_Y: begin
        cmd.axis_y   = 1'b1;
        cmd.mul_load = 1'b1;
      end
      sbcg_pkg::S_ORG_Y: begin
        cmd.axis_y      = 1'b1;
        cmd.origin_load = 1'b1;
        cmd.activate    = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

[rtl/scaled_blit_coordinate_generator.sv]
// Top level of the scaled blit coordinate generator.
// Next: result registered the cycle after accept; one per cycle while drawing, if not stalled.
// Start transaction: busy through clipping and two serial restoring divisions (one per axis)
// on a shared divider; an empty result goes via S_CLIP and S_EMPTY to the result register.
// Synchronous active-high reset: idle, not drawing, result invalid, texture size registers 1.
module scaled_blit_coordinate_generator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sbcg_pkg::ADDR_W-1:0]        paddr,
  input  logic [sbcg_pkg::DATA_W-1:0]        pwdata,
  output logic [sbcg_pkg::DATA_W-1:0]        prdata,
  output logic                               pready,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic                               op,
  input  logic signed [sbcg_pkg::POS_W-1:0]  dest_x,
  input  logic signed [sbcg_pkg::POS_W-1:0]  dest_y,
  input  logic signed [sbcg_pkg::SIZE_W-1:0] dest_w,
  input  logic signed [sbcg_pkg::SIZE_W-1:0] dest_h,
  input  logic signed [sbcg_pkg::POS_W-1:0]  src_x,
  input  logic signed [sbcg_pkg::POS_W-1:0]  src_y,
  input  logic [sbcg_pkg::TEX_W-1:0]         src_w,
  input  logic [sbcg_pkg::TEX_W-1:0]         src_h,
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic                               empty_res,
  output logic [sbcg_pkg::SX_W-1:0]          screen_x,
  output logic [sbcg_pkg::SY_W-1:0]          screen_y,
  output logic [sbcg_pkg::TEX_W-1:0]         tex_x,
  output logic [sbcg_pkg::TEX_W-1:0]         tex_y,
  output logic                               last
);

  sbcg_pkg::cmd_t             cmd;
  sbcg_pkg::status_t          status;
  logic [sbcg_pkg::TEX_W-1:0] tex_width;
  logic [sbcg_pkg::TEX_W-1:0] tex_height;

  sbcg_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .tex_width  (tex_width),
    .tex_height (tex_height)
  );

  sbcg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .op         (op),
    .status     (status),
    .cmd        (cmd)
  );

  sbcg_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .tex_width  (tex_width),
    .tex_height (tex_height),
    .dest_x     (dest_x),
    .dest_y     (dest_y),
    .dest_w     (dest_w),
    .dest_h     (dest_h),
    .src_x      (src_x),
    .src_y      (src_y),
    .src_w      (src_w),
    .src_h      (src_h),
    .res_stall  (res_stall),
    .res_valid  (res_valid),
    .empty_res  (empty_res),
    .screen_x   (screen_x),
    .screen_y   (screen_y),
    .tex_x      (tex_x),
    .tex_y      (tex_y),
    .last       (last)
  );

endmodule
